/* sv/plk_pkg.sv */
// Shared types and constants for the positional list engine.
// Used by plk_cell and positional_list_engine; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package plk_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int POS_W    = 5;
    localparam int SIZE_W   = 5;

    // Operation selector carried in tuser
    typedef enum logic [1:0] {
        KIND_INSERT  = 2'd0,
        KIND_REMOVE  = 2'd1,
        KIND_REPLACE = 2'd2
    } t_kind;

    // Result status
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic                    en;
        t_kind                   kind;
        logic [IDX_W-1:0]        slot;
        logic [CNT_W-1:0]        count;
        logic signed [VAL_W-1:0] value;
    } t_cell_cmd;

endpackage

`default_nettype wire

/* sv/plk_cell.sv */
// One storage cell of the positional list chain: holds one entry and
// shifts from its left or right neighbor. Depends on plk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plk_cell (
    input  wire logic                            i_clk,
    input  wire logic [plk_pkg::IDX_W-1:0]       i_index,
    input  wire plk_pkg::t_cell_cmd              i_cmd,
    input  wire logic signed [plk_pkg::VAL_W-1:0] i_left,
    input  wire logic signed [plk_pkg::VAL_W-1:0] i_right,
    output logic signed [plk_pkg::VAL_W-1:0]      o_entry,
    output logic signed [plk_pkg::VAL_W-1:0]      o_next
);

    logic signed [plk_pkg::VAL_W-1:0] r_entry;
    logic signed [plk_pkg::VAL_W-1:0] n_entry;
    logic [plk_pkg::CNT_W-1:0]        w_idx_ext;

    assign w_idx_ext = plk_pkg::CNT_W'(i_index);

    // Pick the next entry: hold, take neighbor, or load the new value
    always_comb begin
        n_entry = r_entry;
        if (i_cmd.en) begin
            case (i_cmd.kind)
                plk_pkg::KIND_INSERT: begin
                    if (i_index == i_cmd.slot) begin
                        n_entry = i_cmd.value;
                    end else if (i_index > i_cmd.slot && w_idx_ext <= i_cmd.count) begin
                        n_entry = i_left;
                    end
                end
                plk_pkg::KIND_REMOVE: begin
                    if (i_index >= i_cmd.slot &&
                        (w_idx_ext + plk_pkg::CNT_W'(1)) < i_cmd.count) begin
                        n_entry = i_right;
                    end
                end
                plk_pkg::KIND_REPLACE: begin
                    if (i_index == i_cmd.slot) begin
                        n_entry = i_cmd.value;
                    end
                end
                default: begin
                    n_entry = r_entry;
                end
            endcase
        end
    end

    // Store the entry; payload, no reset
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_next  = n_entry;

endmodule

`default_nettype wire

/* sv/positional_list_engine.sv */
// Positional list engine: one operation (insert, remove, replace) per beat.
// A result beat is registered and becomes valid in the cycle after its input beat is accepted.
// Throughput: one operation per cycle while results are taken; the whole cell chain shifts at once.
// A new beat enters only while no result waits or the waiting one leaves in
// the same cycle; a result held by the receiver stalls the input.
// Reset (synchronous, active low) empties the list and drops any pending
// result; the entry cells themselves are not cleared.
// Depends on plk_pkg and plk_cell.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_engine (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [39:0]  i_s_tdata,  // position[4:0], item_value[36:5], zero pad
    input  wire logic [1:0]   i_s_tuser,  // kind[1:0]
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [103:0]      o_m_tdata   // old_value[31:0], status[33:32],
                                          // size_after[38:34], first_value[70:39],
                                          // last_value[102:71], is_empty[103]
);

    localparam int CAP = plk_pkg::CAPACITY;

    logic [plk_pkg::CNT_W-1:0]         r_count;
    logic [plk_pkg::CNT_W-1:0]         n_count;
    logic                              r_out_valid;
    logic [103:0]                      r_out_data;
    logic [103:0]                      n_out_data;

    logic                              w_accept;
    plk_pkg::t_kind                    w_kind;
    logic [plk_pkg::POS_W-1:0]         w_pos;
    logic signed [plk_pkg::VAL_W-1:0]  w_value;
    logic [plk_pkg::CNT_W:0]           w_pos_ext;
    logic [plk_pkg::CNT_W:0]           w_cnt_ext;
    logic                              w_pos_zero;
    logic                              w_ins_range;
    logic                              w_at_range;
    logic                              w_full;
    logic                              w_ok;
    plk_pkg::t_status                  w_status;
    plk_pkg::t_cell_cmd                w_cmd;
    logic [plk_pkg::IDX_W-1:0]         w_slot;
    logic [plk_pkg::IDX_W-1:0]         w_last_slot;
    logic signed [plk_pkg::VAL_W-1:0]  w_entry [CAP];
    logic signed [plk_pkg::VAL_W-1:0]  w_next  [CAP];
    logic signed [plk_pkg::VAL_W-1:0]  w_old;
    logic signed [plk_pkg::VAL_W-1:0]  w_first;
    logic signed [plk_pkg::VAL_W-1:0]  w_last;

    // Unpack the input beat
    assign w_kind  = plk_pkg::t_kind'(i_s_tuser);
    assign w_pos   = i_s_tdata[4:0];
    assign w_value = i_s_tdata[36:5];

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;

    // Range and fullness checks
    assign w_pos_ext   = (plk_pkg::CNT_W + 1)'(w_pos);
    assign w_cnt_ext   = (plk_pkg::CNT_W + 1)'(r_count);
    assign w_pos_zero  = (w_pos == '0);
    assign w_ins_range = !w_pos_zero && (w_pos_ext <= w_cnt_ext + (plk_pkg::CNT_W + 1)'(1));
    assign w_at_range  = !w_pos_zero && (w_pos_ext <= w_cnt_ext);
    assign w_full      = (r_count == plk_pkg::CNT_W'(CAP));
    assign w_slot      = plk_pkg::IDX_W'(w_pos - plk_pkg::POS_W'(1));

    always_comb begin
        w_ok     = 1'b0;
        w_status = plk_pkg::ST_RANGE;
        n_count  = r_count;
        case (w_kind)
            plk_pkg::KIND_INSERT: begin
                if (!w_ins_range) begin
                    w_status = plk_pkg::ST_RANGE;
                end else if (w_full) begin
                    w_status = plk_pkg::ST_FULL;
                end else begin
                    w_status = plk_pkg::ST_DONE;
                    w_ok     = 1'b1;
                    n_count  = r_count + plk_pkg::CNT_W'(1);
                end
            end
            plk_pkg::KIND_REMOVE: begin
                if (w_at_range) begin
                    w_status = plk_pkg::ST_DONE;
                    w_ok     = 1'b1;
                    n_count  = r_count - plk_pkg::CNT_W'(1);
                end
            end
            plk_pkg::KIND_REPLACE: begin
                if (w_at_range) begin
                    w_status = plk_pkg::ST_DONE;
                    w_ok     = 1'b1;
                end
            end
            default: begin
                w_status = plk_pkg::ST_RANGE;
            end
        endcase
    end

    // Broadcast the command down the chain
    assign w_cmd.en    = w_accept && w_ok;
    assign w_cmd.kind  = w_kind;
    assign w_cmd.slot  = w_slot;
    assign w_cmd.count = r_count;
    assign w_cmd.value = w_value;

    // Row of cells, each fed by its neighbors; the end cells get zero on their open side
    for (genvar g = 0; g < CAP; g++) begin : g_cell
        logic signed [plk_pkg::VAL_W-1:0] w_left;
        logic signed [plk_pkg::VAL_W-1:0] w_right;
        if (g == 0) begin : g_lo
            assign w_left = '0;
        end else begin : g_lo_n
            assign w_left = w_entry[g-1];
        end
        if (g == CAP - 1) begin : g_hi
            assign w_right = '0;
        end else begin : g_hi_n
            assign w_right = w_entry[g+1];
        end
        plk_cell u_cell (
            .i_clk   (i_clk),
            .i_index (plk_pkg::IDX_W'(g)),
            .i_cmd   (w_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[g]),
            .o_next  (w_next[g])
        );
    end

    // Select old, first and last values
    assign w_last_slot = plk_pkg::IDX_W'(n_count - plk_pkg::CNT_W'(1));

    always_comb begin
        w_old  = '0;
        w_last = '0;
        for (int k = 0; k < CAP; k++) begin
            if (w_ok && w_kind != plk_pkg::KIND_INSERT &&
                w_slot == plk_pkg::IDX_W'(k)) begin
                w_old = w_old | w_entry[k];
            end
            if (n_count != '0 && w_last_slot == plk_pkg::IDX_W'(k)) begin
                w_last = w_last | w_next[k];
            end
        end
        w_first = (n_count != '0) ? w_next[0] : '0;
    end

    // Pack the result beat
    assign n_out_data = {(n_count == '0), w_last, w_first,
                         plk_pkg::SIZE_W'(n_count), w_status, w_old};

    // Count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= plk_pkg::CNT_W'(CAP))
        else $error("element count above capacity");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data[103] == (r_out_data[38:34] == '0)))
        else $error("empty flag disagrees with size");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_ok && w_kind == plk_pkg::KIND_INSERT)
        |=> (r_count == $past(r_count) + plk_pkg::CNT_W'(1)))
        else $error("insert did not grow the list");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_status == plk_pkg::ST_FULL) |-> w_full)
        else $error("full status on a list with room");

endmodule

`default_nettype wire
